// File: sv/htd_pkg.sv
// Package for the Huffman tree-walk decoder: item structs, config indexes,
// opcodes, state encoding and the emit request bundle. No dependencies.
`timescale 1ns / 1ps

package htd_pkg;

    localparam int IDX_W      = 9;   // node index width
    localparam int SYM_W      = 8;   // symbol width on the ports
    localparam int BYTE_W     = 8;
    localparam int CNT_W      = 4;   // holds 0..8 remaining bits
    localparam int PAD_W      = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_NODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_BITS  = 1'b1;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [IDX_W-1:0]  node_index;
        logic              node_is_leaf;
        logic [SYM_W-1:0]  node_symbol;
        logic [IDX_W-1:0]  left_child;
        logic [IDX_W-1:0]  right_child;
        logic [BYTE_W-1:0] data_byte;
        logic              final_byte;
    } t_in_item;

    typedef struct packed {
        logic [SYM_W-1:0] decoded_symbol;
        logic             run_last;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REFRESH,
        ST_DECODE
    } t_state;

    // emit: a leaf was reached this step; flush: byte done, release held symbol
    typedef struct packed {
        logic             emit;
        logic             flush;
        logic [SYM_W-1:0] sym;
    } t_emit_req;

endpackage

// File: sv/huffman_tree_decoder.sv
// Huffman tree-walk decoder: load items fill the node memory, decode items walk one tree
// step per compressed bit, one dependent node memory read per cycle while the output does
// not stall (the read is registered). A decode item needs an additional walk step when a
// code ends on the byte's last bit or lands on a leaf root; it stalls while the output is full.
// Writing root_node fetches the root node through ST_REFRESH. Synchronous active-low reset
// clears control state; the node memory has no reset and is undefined until loaded.
`timescale 1ns / 1ps

module huffman_tree_decoder
    import htd_pkg::*;
#(
    parameter int NODE_COUNT  = 511,
    parameter int SYMBOL_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW    = $clog2(NODE_COUNT);
    localparam int ENT_W = 1 + SYMBOL_BITS + 2 * IDX_W;

    // node entry: leaf | symbol | left | right
    logic [ENT_W-1:0] node_mem [NODE_COUNT];

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_root, n_root;
    logic [PAD_W-1:0] r_pad, n_pad;
    logic [IDX_W-1:0] r_walk, n_walk;
    logic [ENT_W-1:0] r_cur, n_cur;
    logic [ENT_W-1:0] r_rootent, n_rootent;
    logic             r_fresh, n_fresh;
    logic             r_chk, n_chk;
    logic [BYTE_W-1:0] r_bits, n_bits;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_fin, n_fin;
    logic             r_rd_ok;
    logic [ENT_W-1:0] r_rd_data;

    logic             in_acc;
    logic             cfg_root_wr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             wr_en;
    logic [ENT_W-1:0] wr_ent;
    logic             ld_in_range;

    logic [ENT_W-1:0] cur_ent, base_ent, rd_ent;
    logic             cur_leaf, base_leaf;
    logic             emit_a, have_bit, take_bit, move, emit, finish, to_root;
    logic [IDX_W-1:0] child;
    logic             go, step;
    t_emit_req        req;

    assign cfg_root_wr = i_cfg_we && (i_cfg_index == CFG_ROOT_NODE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign ld_in_range = 32'(i_in_item.node_index) < 32'(NODE_COUNT);

    assign wr_ent = {i_in_item.node_is_leaf, SYMBOL_BITS'(i_in_item.node_symbol),
                     i_in_item.left_child, i_in_item.right_child};

    // current node: straight from the memory right after a child move
    assign rd_ent    = r_rd_ok ? r_rd_data : '0;
    assign cur_ent   = r_fresh ? rd_ent : r_cur;
    assign cur_leaf  = cur_ent[ENT_W-1];
    // a child reached by the last bit that is a leaf emits and restarts at the root
    assign emit_a    = r_chk && cur_leaf;
    assign base_ent  = emit_a ? r_rootent : cur_ent;
    assign base_leaf = base_ent[ENT_W-1];
    assign have_bit  = (r_cnt != '0);
    assign take_bit  = have_bit && !(emit_a && base_leaf);
    assign move      = take_bit && !base_leaf;
    assign emit      = emit_a || (take_bit && base_leaf);
    assign finish    = !emit_a && !have_bit;
    assign to_root   = emit && !move;
    assign child     = r_bits[BYTE_W-1] ? base_ent[IDX_W-1:0] : base_ent[2*IDX_W-1:IDX_W];

    assign req.emit  = (r_state == ST_DECODE) && emit;
    assign req.flush = (r_state == ST_DECODE) && finish;
    assign req.sym   = SYM_W'(emit_a ? cur_ent[ENT_W-2 -: SYMBOL_BITS]
                                     : base_ent[ENT_W-2 -: SYMBOL_BITS]);

    assign step = (r_state == ST_DECODE) && go;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (cfg_root_wr) begin
                    n_state = ST_REFRESH;
                end else if (in_acc && i_in_item.opcode == OP_DECODE) begin
                    n_state = ST_DECODE;
                end
            end
            ST_REFRESH: n_state = ST_IDLE;
            ST_DECODE: begin
                if (go && finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        rd_en      = 1'b0;
        rd_idx     = child;
        wr_en      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = !cfg_root_wr;
                rd_en      = cfg_root_wr;
                rd_idx     = i_cfg_data[IDX_W-1:0];
                wr_en      = in_acc && i_in_item.opcode == OP_LOAD && ld_in_range;
            end
            ST_REFRESH: begin
                o_in_ready = 1'b0;
            end
            ST_DECODE: begin
                rd_en  = step && move;
                rd_idx = child;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // walk datapath
    always_comb begin
        n_root    = r_root;
        n_pad     = r_pad;
        n_walk    = r_walk;
        n_cur     = r_cur;
        n_rootent = r_rootent;
        n_fresh   = r_fresh;
        n_chk     = r_chk;
        n_bits    = r_bits;
        n_cnt     = r_cnt;
        n_fin     = r_fin;

        if (i_cfg_we && i_cfg_index == CFG_PAD_BITS) begin
            n_pad = i_cfg_data[PAD_W-1:0];
        end
        if (cfg_root_wr) begin
            n_root = i_cfg_data[IDX_W-1:0];
            n_walk = i_cfg_data[IDX_W-1:0];
        end

        if (r_state == ST_REFRESH) begin
            n_rootent = rd_ent;
            n_cur     = rd_ent;
            n_fresh   = 1'b0;
            n_chk     = 1'b0;
        end

        if (wr_en) begin
            // keep the cached root and walk nodes coherent with the table
            if (i_in_item.node_index == r_root) begin
                n_rootent = wr_ent;
            end
            if (i_in_item.node_index == r_walk) begin
                n_cur = wr_ent;
            end
        end

        if (in_acc && i_in_item.opcode == OP_DECODE) begin
            n_bits = i_in_item.data_byte;
            n_cnt  = i_in_item.final_byte ? (CNT_W'(BYTE_W) - CNT_W'(r_pad)) : CNT_W'(BYTE_W);
            n_fin  = i_in_item.final_byte;
        end

        if (step) begin
            if (take_bit) begin
                n_bits = r_bits << 1;
                n_cnt  = r_cnt - 1'b1;
            end
            if (move) begin
                n_walk  = child;
                n_fresh = 1'b1;
                n_chk   = 1'b1;
            end else if (to_root) begin
                n_walk  = r_root;
                n_cur   = r_rootent;
                n_fresh = 1'b0;
                n_chk   = 1'b0;
            end else if (finish) begin
                n_fresh = 1'b0;
                n_chk   = 1'b0;
                if (r_fin) begin
                    n_walk = r_root;
                    n_cur  = r_rootent;
                end else begin
                    n_cur = cur_ent;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_root    <= '0;
            r_pad     <= '0;
            r_walk    <= '0;
            r_cur     <= '0;
            r_rootent <= '0;
            r_fresh   <= 1'b0;
            r_chk     <= 1'b0;
            r_cnt     <= '0;
            r_fin     <= 1'b0;
            r_rd_ok   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_root    <= n_root;
            r_pad     <= n_pad;
            r_walk    <= n_walk;
            r_cur     <= n_cur;
            r_rootent <= n_rootent;
            r_fresh   <= n_fresh;
            r_chk     <= n_chk;
            r_cnt     <= n_cnt;
            r_fin     <= n_fin;
            if (rd_en) begin
                r_rd_ok <= 32'(rd_idx) < 32'(NODE_COUNT);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits <= n_bits;
    end

    // node memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            node_mem[AW'(i_in_item.node_index)] <= wr_ent;
        end
        if (rd_en) begin
            r_rd_data <= node_mem[AW'(rd_idx)];
        end
    end

    htd_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .o_go        (go),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

`ifndef ASSERT_OFF
    a_chk_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk |-> r_fresh)
        else $error("pending leaf check without a fresh node read");

    a_idle_cached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!r_fresh && !r_chk))
        else $error("walk node not cached while idle");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(BYTE_W))
        else $error("bit count out of range");

    a_decode_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_item.opcode == OP_DECODE) |=> (r_state == ST_DECODE))
        else $error("decode item accepted but walk did not start");

    a_move_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && move) |=> r_fresh)
        else $error("child move without memory read");
`endif

endmodule

// File: sv/htd_emit.sv
// Output side of the decoder: holds the newest symbol until it is known
// whether it ends the byte, then pushes it into the output register. Uses htd_pkg.
`timescale 1ns / 1ps

module htd_emit
    import htd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_emit_req i_req,
    output logic      o_go,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic             r_hold_vld;
    logic [SYM_W-1:0] r_hold_sym;
    logic             r_out_vld;
    t_out_item        r_out;

    logic need_push;
    logic out_free;
    logic push;

    assign need_push = r_hold_vld && (i_req.emit || i_req.flush);
    assign out_free  = !r_out_vld || i_out_ready;
    assign o_go      = !need_push || out_free;
    assign push      = need_push && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (push) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_req.emit && o_go) begin
                r_hold_vld <= 1'b1;
            end else if (i_req.flush && o_go) begin
                r_hold_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out.decoded_symbol <= r_hold_sym;
            r_out.run_last       <= i_req.flush;
        end
        if (i_req.emit && o_go) begin
            r_hold_sym <= i_req.sym;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

// File: dv/huffman_tree_decoder_test.sv
// Testbench for huffman_tree_decoder: loads code trees, streams compressed bytes and
// checks every decoded symbol against a tree-walk predictor kept in a scoreboard class.
// Depends on sv/htd_pkg.sv, sv/huffman_tree_decoder.sv and sv/htd_emit.sv.
`timescale 1ns / 1ps

module huffman_tree_decoder_test;
    import htd_pkg::*;

    localparam int NODE_COUNT    = 511;
    localparam int ITEM_TARGET   = 450;
    localparam int SETTLE_CYCLES = 16;
    // one past the table: reads as an empty interior node whose children are both 0
    localparam logic [IDX_W-1:0] NO_NODE = 9'h1FF;

    typedef struct packed {
        logic             leaf;
        logic [SYM_W-1:0] sym;
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
    } t_tree_node;

    class symbol_tracker;
        t_tree_node       nodes [NODE_COUNT];
        logic [IDX_W-1:0] root;
        logic [IDX_W-1:0] walk;
        logic [PAD_W-1:0] pad;
        t_out_item        pending_symbols [$];
        int               errors;
        int               checked;

        function new();
            root = '0;
            walk = '0;
            pad = '0;
            errors = 0;
            checked = 0;
            foreach (nodes[i]) nodes[i] = '0;
        endfunction

        function t_tree_node fetch(logic [IDX_W-1:0] idx);
            if (idx >= NODE_COUNT) return '0;
            return nodes[idx];
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_ROOT_NODE) begin
                root = data[IDX_W-1:0];
                walk = root;
            end else begin
                pad = data[PAD_W-1:0];
            end
        endfunction

        // Stores a load item in the node table, or walks the tree for a decode item and queues the symbols it yields.
        function void take_item(t_in_item it);
            logic [SYM_W-1:0] found [$];
            t_tree_node       cur;
            t_out_item        sym;
            int               nbits;
            if (it.opcode == OP_LOAD) begin
                if (it.node_index < NODE_COUNT) begin
                    cur.leaf  = it.node_is_leaf;
                    cur.sym   = it.node_symbol;
                    cur.left  = it.left_child;
                    cur.right = it.right_child;
                    nodes[it.node_index] = cur;
                end
                return;
            end
            nbits = it.final_byte ? 8 - int'(pad) : 8;
            for (int i = 0; i < nbits; i++) begin
                cur = fetch(walk);
                // a leaf already under the walk eats this bit without stepping
                if (!cur.leaf) begin
                    walk = it.data_byte[7 - i] ? cur.right : cur.left;
                    cur = fetch(walk);
                end
                if (cur.leaf) begin
                    found.push_back(cur.sym);
                    walk = root;
                end
            end
            foreach (found[k]) begin
                sym.decoded_symbol = found[k];
                sym.run_last = (k == found.size() - 1);
                pending_symbols.push_back(sym);
            end
            if (it.final_byte) walk = root;
        endfunction

        function void check_symbol(t_out_item got);
            t_out_item want;
            checked++;
            if (pending_symbols.size() == 0) begin
                $error("unexpected symbol %02h (run_last %0b)", got.decoded_symbol, got.run_last);
                errors++;
                return;
            end
            want = pending_symbols.pop_front();
            if (got.decoded_symbol !== want.decoded_symbol) begin
                $error("decoded_symbol: expected %02h, got %02h",
                       want.decoded_symbol, got.decoded_symbol);
                errors++;
            end
            if (got.run_last !== want.run_last) begin
                $error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_item              i_in_item;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_item             o_out_item;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    symbol_tracker          tracker;
    bit                     calm;
    bit                     stall_on;
    bit [NODE_COUNT-1:0]    taken;
    logic [IDX_W-1:0]       cur_root;
    int                     items_sent;
    int                     loads_sent;
    int                     bytes_sent;
    int                     reg_writes;

    huffman_tree_decoder #(
        .NODE_COUNT (NODE_COUNT),
        .SYMBOL_BITS(SYM_W)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) tracker.take_item(i_in_item);
            if (o_out_valid && i_out_ready) tracker.check_symbol(o_out_item);
        end
    end

    // Output back-pressure: stall bursts come and go in windows.
    initial begin
        i_out_ready <= 1'b0;
        stall_on = 1'b1;
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 99) == 0) stall_on = !stall_on;
            if (!calm && stall_on && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Returns at the edge that accepts the item, with valid still high.
    task automatic send_item(t_in_item it);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(negedge i_clk); while (!o_in_ready);
        @(posedge i_clk);
        items_sent++;
    endtask

    task automatic load_node(int idx, bit leaf, logic [SYM_W-1:0] sym,
                             logic [IDX_W-1:0] left, logic [IDX_W-1:0] right);
        t_in_item it;
        it.opcode       = OP_LOAD;
        it.node_index   = idx[IDX_W-1:0];
        it.node_is_leaf = leaf;
        it.node_symbol  = sym;
        it.left_child   = left;
        it.right_child  = right;
        it.data_byte    = BYTE_W'($urandom);
        it.final_byte   = 1'($urandom);
        send_item(it);
        loads_sent++;
    endtask

    task automatic decode_byte(logic [BYTE_W-1:0] data, bit fin);
        t_in_item it;
        it.opcode       = OP_DECODE;
        it.node_index   = IDX_W'($urandom);
        it.node_is_leaf = 1'($urandom);
        it.node_symbol  = SYM_W'($urandom);
        it.left_child   = IDX_W'($urandom);
        it.right_child  = IDX_W'($urandom);
        it.data_byte    = data;
        it.final_byte   = fin;
        send_item(it);
        bytes_sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        tracker.write_reg(idx, data);
        if (idx == CFG_ROOT_NODE) cur_root = data;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        reg_writes++;
    endtask

    // Block must be idle before a register write.
    task automatic drain();
        i_in_valid <= 1'b0;
        // let the monitor note the last accepted item first
        @(posedge i_clk);
        while (tracker.pending_symbols.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic int grab_free_node();
        int idx;
        do idx = $urandom_range(0, NODE_COUNT - 1); while (taken[idx]);
        taken[idx] = 1'b1;
        return idx;
    endfunction

    // Loads a random tree bottom-up so that every interior node only points at nodes
    // already written (or past the table, which leads back to node 0).
    task automatic plant_tree(int root_at, int nleaves, bit chain, output int top);
        int               pool [$];
        int               a, b, k, idx;
        logic [IDX_W-1:0] left, right;
        taken = '0;
        if (root_at >= 0) taken[root_at] = 1'b1;
        for (k = 0; k < nleaves; k++) begin
            idx = (nleaves == 1 && root_at >= 0) ? root_at : grab_free_node();
            load_node(idx, 1'b1, SYM_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
            pool.push_back(idx);
        end
        while (pool.size() > 1) begin
            if (chain) begin
                a = pool.pop_back();
                b = pool.pop_front();
            end else begin
                k = $urandom_range(0, pool.size() - 1);
                a = pool[k];
                pool.delete(k);
                k = $urandom_range(0, pool.size() - 1);
                b = pool[k];
                pool.delete(k);
            end
            idx = (pool.size() == 0 && root_at >= 0) ? root_at : grab_free_node();
            if ($urandom_range(0, 1)) begin
                left = IDX_W'(a);
                right = IDX_W'(b);
            end else begin
                left = IDX_W'(b);
                right = IDX_W'(a);
            end
            // now and then a branch escapes the table or jumps to node 0
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1)) left = $urandom_range(0, 1) ? NO_NODE : '0;
                else right = $urandom_range(0, 1) ? NO_NODE : '0;
            end
            load_node(idx, 1'b0, SYM_W'($urandom), left, right);
            pool.push_back(idx);
        end
        top = pool[0];
    endtask

    initial begin
        int top, nleaves, sel;
        bit chain;
        logic [PAD_W-1:0] pad;
        tracker = new();
        calm = 1'b0;
        items_sent = 0;
        loads_sent = 0;
        bytes_sent = 0;
        reg_writes = 0;
        cur_root = '0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single-symbol tree: the root leaf eats one bit per symbol
        write_reg(CFG_ROOT_NODE, '0);
        write_reg(CFG_PAD_BITS, '0);
        load_node(0, 1'b1, 8'hA5, NO_NODE, '0);
        decode_byte(8'h00, 1'b0);
        decode_byte(8'hFF, 1'b1);
        load_node(NO_NODE, 1'b1, 8'h00, NO_NODE, NO_NODE);   // dropped, beyond table
        // root at top of table, right branch runs off the table into node 0
        load_node(509, 1'b1, 8'h00, '0, '0);
        load_node(510, 1'b0, 8'hFF, 9'd509, NO_NODE);
        drain();
        write_reg(CFG_ROOT_NODE, 9'd510);
        write_reg(CFG_PAD_BITS, 9'h1FF);
        decode_byte(8'h5A, 1'b0);
        decode_byte(8'h80, 1'b1);   // one bit left, code unfinished and dropped
        decode_byte(8'h7F, 1'b1);
        drain();
        write_reg(CFG_ROOT_NODE, NO_NODE);
        write_reg(CFG_PAD_BITS, 9'd3);
        decode_byte(8'h96, 1'b0);
        decode_byte(8'h3C, 1'b1);
        // deep chain so codes straddle byte boundaries
        plant_tree(-1, 5, 1'b1, top);
        drain();
        write_reg(CFG_ROOT_NODE, IDX_W'(top));
        write_reg(CFG_PAD_BITS, '0);
        decode_byte(8'hFF, 1'b0);
        decode_byte(8'hF0, 1'b0);
        decode_byte(8'h0F, 1'b1);

        while (items_sent < ITEM_TARGET) begin
            calm = (items_sent > ITEM_TARGET - 60);
            sel = $urandom_range(0, 19);
            chain = 1'b0;
            if (sel == 0) begin
                nleaves = 1;
            end else if (sel == 1) begin
                nleaves = $urandom_range(20, 40);
            end else if (sel < 5) begin
                nleaves = $urandom_range(6, 14);
                chain = 1'b1;
            end else begin
                nleaves = $urandom_range(2, 8);
            end
            if ($urandom_range(0, 1)) begin
                plant_tree(-1, nleaves, chain, top);
                drain();
                write_reg(CFG_ROOT_NODE, ($urandom_range(0, 15) == 0) ? NO_NODE : IDX_W'(top));
                if ($urandom_range(0, 1)) begin
                    sel = $urandom_range(0, 3);
                    pad = (sel == 0) ? 3'd0 : (sel == 1) ? 3'd7 : PAD_W'($urandom);
                    write_reg(CFG_PAD_BITS, {6'($urandom), pad});
                end
            end else begin
                // reload in place under the live root, possibly mid-code
                plant_tree((cur_root >= NODE_COUNT) ? 0 : int'(cur_root), nleaves, chain, top);
            end
            if ($urandom_range(0, 7) == 0)
                load_node(NO_NODE, 1'($urandom), SYM_W'($urandom), IDX_W'($urandom),
                          IDX_W'($urandom));
            repeat ($urandom_range(3, 16))
                decode_byte(BYTE_W'($urandom), $urandom_range(0, 7) == 0);
            if ($urandom_range(0, 1)) decode_byte(BYTE_W'($urandom), 1'b1);
        end

        drain();
        if (tracker.pending_symbols.size() != 0) begin
            $error("decoded_symbol: expected %0d more symbols, got none",
                   tracker.pending_symbols.size());
            tracker.errors++;
        end
        $display("Run: %0d node loads, %0d compressed bytes, %0d register writes.",
                 loads_sent, bytes_sent, reg_writes);
        $display("Symbols checked: %0d, mismatches: %0d.", tracker.checked, tracker.errors);
        if (tracker.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
